>>> hw/rtl/bpra_pkg.sv
// Package for the bitmap page-run allocator.
// Holds the map geometry, widths, action codes and the controller state type.
// No dependencies.
package bpra_pkg;

  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned MAP_PAGES  = 32768;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned MAP_WORDS  = (MAP_PAGES + 31) / 32;
  localparam int unsigned MP_W       = $clog2(MAP_PAGES + 1);
  localparam int unsigned WA_W       = $clog2(MAP_WORDS);
  localparam int unsigned WIDE_W     = 34;

  localparam logic [31:0] LOW_SAFE_START = 32'h0010_0000;
  localparam logic [31:0] WORD_ALL_USED  = 32'hFFFF_FFFF;

  typedef logic [MP_W-1:0] page_t;
  typedef logic [WA_W-1:0] word_addr_t;

  typedef enum logic [1:0] {
    ACT_INIT    = 2'd0,
    ACT_ALLOC   = 2'd1,
    ACT_FREE    = 2'd2,
    ACT_RESERVE = 2'd3
  } action_t;

  typedef enum logic [0:0] {
    CFG_MEMORY_BYTES = 1'b0,
    CFG_KERNEL_END   = 1'b1
  } cfg_index_t;

  typedef enum logic [6:0] {
    ST_CLEAR    = 7'b0000001,
    ST_IDLE     = 7'b0000010,
    ST_FILL     = 7'b0000100,
    ST_SCAN_RD  = 7'b0001000,
    ST_SCAN_BIT = 7'b0010000,
    ST_RW_RD    = 7'b0100000,
    ST_RW_WR    = 7'b1000000
  } state_t;

endpackage

>>> hw/rtl/bpra_if.sv
// Handshake channel interfaces for the bitmap page-run allocator.
// Depends on nothing; payload widths follow the request and result beats.
interface bpra_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] address;
  logic [15:0] page_count;
  logic [31:0] byte_length;

  modport source (output valid, action, address, page_count, byte_length, input ready);
  modport sink (input valid, action, address, page_count, byte_length, output ready);
endinterface

interface bpra_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] run_address;
  logic        status;

  modport source (output valid, run_address, status, input ready);
  modport sink (input valid, run_address, status, output ready);
endinterface

>>> hw/rtl/bpra_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module bpra_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/bitmap_page_run_allocator_core.sv
// Top level of the bitmap page-run allocator: sequencer around one map RAM.
// Depends on bpra_pkg, bpra_if and bpra_ram.
//
// The page map sits in a 32-bit-wide RAM, one bit per page, 1 meaning used.
// After reset the block sweeps the RAM to all free, one word a cycle, and
// takes no request meanwhile. Requests are handled one at a time and each
// gives one result beat. Free, reserve and the range part of init read each
// map word touched, then write it back. Init first sweeps every word to used,
// one a cycle. Alloc scans the map one page per cycle, but with a read state
// before each map word, and is followed by the marking pass over the run found.
module bitmap_page_run_allocator_core (
  input  logic                    clk,
  input  logic                    rst_n,
  bpra_in_if.sink                 in_ch,
  bpra_out_if.source              out_ch,
  input  logic                    cfg_we,
  input  bpra_pkg::cfg_index_t    cfg_index,
  input  logic [31:0]             cfg_wdata
);
  import bpra_pkg::*;

  state_t      state_r, state_nxt;
  word_addr_t  w_r, w_nxt;
  page_t       lo_r, lo_nxt, hi_r, hi_nxt;
  page_t       page_r, page_nxt;
  logic [15:0] run_r, run_nxt, count_r, count_nxt;
  logic        set_r, set_nxt, range_ok_r, range_ok_nxt;
  logic [31:0] res_addr_r, res_addr_nxt;
  logic        out_valid_r, out_valid_nxt, out_status_r, out_status_nxt;
  logic [31:0] out_addr_r, out_addr_nxt;
  logic [31:0] mem_bytes_r, kend_r;

  logic        ram_we, ram_re;
  word_addr_t  ram_waddr, ram_raddr;
  logic [31:0] ram_wdata, ram_rdata;

  logic [WIDE_W-1:0] first_w, end_w, start_w, kend_up;
  page_t       lo_c, hi_c;
  logic        in_fire;
  word_addr_t  lo_word, hi_word;
  logic [31:0] mask, m_lo, m_hi;
  page_t       hi_m1, page_inc;
  logic [15:0] run_inc;

  bpra_ram #(.WIDTH(32), .DEPTH(MAP_WORDS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready        = (state_r == ST_IDLE) && !out_valid_r;
  assign in_fire            = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.run_address = out_addr_r;
  assign out_ch.status      = out_status_r;

  // Page range of a request, at full width, then clipped to the map.
  always_comb begin
    kend_up = ((WIDE_W'(kend_r) + WIDE_W'(PAGE_BYTES - 1)) >> PAGE_SHIFT) << PAGE_SHIFT;
    start_w = (kend_r > LOW_SAFE_START) ? kend_up : WIDE_W'(LOW_SAFE_START);
    first_w = WIDE_W'(in_ch.address) >> PAGE_SHIFT;
    end_w   = first_w;
    unique case (action_t'(in_ch.action))
      ACT_INIT: begin
        first_w = start_w >> PAGE_SHIFT;
        end_w   = (WIDE_W'(mem_bytes_r) > start_w) ?
                  ((WIDE_W'(mem_bytes_r) + WIDE_W'(PAGE_BYTES - 1)) >> PAGE_SHIFT) : first_w;
      end
      ACT_FREE:    end_w = first_w + WIDE_W'(in_ch.page_count);
      ACT_RESERVE: end_w = first_w +
                   ((WIDE_W'(in_ch.byte_length) + WIDE_W'(PAGE_BYTES - 1)) >> PAGE_SHIFT);
      default:     end_w = first_w;
    endcase
    lo_c = (first_w > WIDE_W'(MAP_PAGES)) ? MP_W'(MAP_PAGES) : first_w[MP_W-1:0];
    hi_c = (end_w > WIDE_W'(MAP_PAGES)) ? MP_W'(MAP_PAGES) : end_w[MP_W-1:0];
  end

  // Bit mask of the range within the current word.
  always_comb begin
    hi_m1   = hi_r - MP_W'(1);
    lo_word = WA_W'(lo_r >> 5);
    hi_word = WA_W'(hi_m1 >> 5);
    m_lo    = (w_r == lo_word) ? (WORD_ALL_USED << lo_r[4:0]) : WORD_ALL_USED;
    m_hi    = (w_r == hi_word) ? (WORD_ALL_USED >> (5'd31 - hi_m1[4:0])) : WORD_ALL_USED;
    mask    = m_lo & m_hi;
  end

  assign page_inc = page_r + MP_W'(1);
  assign run_inc  = run_r + 16'd1;

  always_comb begin
    state_nxt      = state_r;
    w_nxt          = w_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    page_nxt       = page_r;
    run_nxt        = run_r;
    count_nxt      = count_r;
    set_nxt        = set_r;
    range_ok_nxt   = range_ok_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = w_r;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = w_r;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        w_nxt  = w_r + WA_W'(1);
        if (w_r == WA_W'(MAP_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          lo_nxt       = lo_c;
          hi_nxt       = hi_c;
          range_ok_nxt = lo_c < hi_c;
          res_addr_nxt = '0;
          count_nxt    = in_ch.page_count;
          page_nxt     = '0;
          run_nxt      = '0;
          w_nxt        = WA_W'(lo_c >> 5);
          unique case (action_t'(in_ch.action))
            ACT_INIT: begin
              set_nxt   = 1'b0;
              w_nxt     = '0;
              state_nxt = ST_FILL;
            end
            ACT_ALLOC: begin
              set_nxt = 1'b1;
              if (in_ch.page_count == 16'd0) begin
                out_valid_nxt  = 1'b1;
                out_addr_nxt   = '0;
                out_status_nxt = 1'b1;
              end else begin
                state_nxt = ST_SCAN_RD;
              end
            end
            ACT_FREE, ACT_RESERVE: begin
              set_nxt = (action_t'(in_ch.action) == ACT_RESERVE);
              if (lo_c < hi_c) begin
                state_nxt = ST_RW_RD;
              end else begin
                out_valid_nxt  = 1'b1;
                out_addr_nxt   = '0;
                out_status_nxt = 1'b0;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = WORD_ALL_USED;
        w_nxt     = w_r + WA_W'(1);
        if (w_r == WA_W'(MAP_WORDS - 1)) begin
          if (range_ok_r) begin
            w_nxt     = lo_word;
            state_nxt = ST_RW_RD;
          end else begin
            state_nxt      = ST_IDLE;
            out_valid_nxt  = 1'b1;
            out_addr_nxt   = '0;
            out_status_nxt = 1'b0;
          end
        end
      end
      ST_SCAN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = WA_W'(page_r >> 5);
        state_nxt = ST_SCAN_BIT;
      end
      ST_SCAN_BIT: begin
        if (!ram_rdata[page_r[4:0]] && (run_inc == count_r)) begin
          lo_nxt       = page_inc - MP_W'(count_r);
          hi_nxt       = page_inc;
          w_nxt        = WA_W'((page_inc - MP_W'(count_r)) >> 5);
          res_addr_nxt = 32'((WIDE_W'(page_inc - MP_W'(count_r))) << PAGE_SHIFT);
          state_nxt    = ST_RW_RD;
        end else if (page_r == MP_W'(MAP_PAGES - 1)) begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = '0;
          out_status_nxt = 1'b1;
        end else begin
          page_nxt = page_inc;
          run_nxt  = ram_rdata[page_r[4:0]] ? 16'd0 : run_inc;
          if (page_r[4:0] == 5'd31) begin
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_RW_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_RW_WR;
      end
      ST_RW_WR: begin
        ram_we    = 1'b1;
        ram_wdata = set_r ? (ram_rdata | mask) : (ram_rdata & ~mask);
        w_nxt     = w_r + WA_W'(1);
        if (w_r == hi_word) begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = 1'b0;
        end else begin
          state_nxt = ST_RW_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      w_r         <= '0;
      out_valid_r <= 1'b0;
      mem_bytes_r <= '0;
      kend_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MEMORY_BYTES: mem_bytes_r <= cfg_wdata;
          CFG_KERNEL_END:   kend_r      <= cfg_wdata;
          default:          mem_bytes_r <= mem_bytes_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    page_r       <= page_nxt;
    run_r        <= run_nxt;
    count_r      <= count_nxt;
    set_r        <= set_nxt;
    range_ok_r   <= range_ok_nxt;
    res_addr_r   <= res_addr_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("controller state is not one-hot");

  a_ram_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR || state_r == ST_FILL || state_r == ST_RW_WR))
    else $error("map write outside a write state");

  a_range_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RW_WR) |-> (lo_r < hi_r))
    else $error("read-modify-write on an empty page range");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN_BIT) |=> !$past(in_fire))
    else $error("request taken during a search");

endmodule

>>> verif/bpra_run_checker.sv
// Checker for the bitmap page-run allocator: watches the request, result and register ports.
// Keeps its own page map, predicts each result and compares it with the block's result.
// Depends on bpra_pkg and the bpra_in_if / bpra_out_if channel interfaces.
module bpra_run_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  bpra_in_if                   in_ch,
  bpra_out_if                  out_ch,
  input  logic                 cfg_we,
  input  bpra_pkg::cfg_index_t cfg_index,
  input  logic [31:0]          cfg_wdata,
  output int                   fail_count,
  output int                   pending
);
  import bpra_pkg::*;

  typedef struct {
    logic [31:0] run_address;
    logic        status;
  } run_result_t;

  bit          page_used [0:MAP_PAGES-1];
  logic [31:0] mem_bytes_q;
  logic [31:0] kernel_end_q;
  run_result_t result_q[$];

  function automatic void mark_pages(longint unsigned first, longint unsigned n, bit used);
    longint unsigned last;
    last = first + n;
    if (last > MAP_PAGES) last = MAP_PAGES;
    for (longint unsigned p = first; p < last; p++) page_used[p] = used;
  endfunction

  function automatic longint unsigned pages_for_bytes(longint unsigned len);
    return (len + PAGE_BYTES - 1) / PAGE_BYTES;
  endfunction

  function automatic void init_map();
    longint unsigned free_base;
    longint unsigned mem;
    longint unsigned kend;
    free_base = LOW_SAFE_START;
    mem = mem_bytes_q;
    kend = kernel_end_q;
    for (int p = 0; p < MAP_PAGES; p++) page_used[p] = 1'b1;
    if (kend > free_base) free_base = pages_for_bytes(kend) * PAGE_BYTES;
    if (mem > free_base)
      mark_pages(free_base / PAGE_BYTES, pages_for_bytes(mem - free_base), 1'b0);
  endfunction

  function automatic run_result_t alloc_run(int unsigned count);
    run_result_t r;
    int unsigned run_len;
    longint unsigned first;
    r.run_address = '0;
    r.status = 1'b1;
    run_len = 0;
    if (count == 0) return r;
    for (int p = 0; p < MAP_PAGES; p++) begin
      if (page_used[p]) begin
        run_len = 0;
      end else begin
        run_len++;
        if (run_len == count) begin
          first = p + 1 - count;
          mark_pages(first, count, 1'b1);
          r.run_address = 32'(first * PAGE_BYTES);
          r.status = 1'b0;
          return r;
        end
      end
    end
    return r;
  endfunction

  function automatic run_result_t predict_request(action_t act, logic [31:0] addr,
                                                   logic [15:0] count, logic [31:0] len);
    run_result_t r;
    r.run_address = '0;
    r.status = 1'b0;
    case (act)
      ACT_INIT: init_map();
      ACT_ALLOC: r = alloc_run(count);
      ACT_FREE: mark_pages(longint'(addr) / PAGE_BYTES, count, 1'b0);
      default: mark_pages(longint'(addr) / PAGE_BYTES, pages_for_bytes(len), 1'b1);
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    run_result_t got;
    run_result_t want;
    if (!rst_n) begin
      for (int p = 0; p < MAP_PAGES; p++) page_used[p] = 1'b0;
      mem_bytes_q = '0;
      kernel_end_q = '0;
      result_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MEMORY_BYTES: mem_bytes_q = cfg_wdata;
          CFG_KERNEL_END: kernel_end_q = cfg_wdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        result_q.push_back(predict_request(action_t'(in_ch.action), in_ch.address,
                                           in_ch.page_count, in_ch.byte_length));
      if (out_ch.valid && out_ch.ready) begin
        got.run_address = out_ch.run_address;
        got.status = out_ch.status;
        if (result_q.size() == 0) begin
          $error("result beat with nothing expected: run_address %h status %0d",
                 got.run_address, got.status);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (got.run_address !== want.run_address) begin
            $error("run_address expected %h actual %h", want.run_address, got.run_address);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            fail_count++;
          end
        end
      end
    end
    pending = result_q.size();
  end
endmodule

>>> verif/tb_top.sv
// Top of the bitmap page-run allocator testbench: clock, reset, requests and verdict.
// Drives directed and random request beats and register writes; bpra_run_checker compares.
// Depends on bpra_pkg, the channel interfaces, the core and bpra_run_checker.
module tb_top;
  import bpra_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_index_t  cfg_index;
  logic [31:0] cfg_wdata;
  int          fail_count;
  int          pending;
  bit          idle_on;
  bit          rx_hold;

  bpra_in_if  in_ch();
  bpra_out_if out_ch();

  bitmap_page_run_allocator_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  bpra_run_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #(64'd800_000_000);
    $display("bitmap_page_run_allocator_core: mismatch");
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      if (rx_hold) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_request(action_t act, logic [31:0] addr, logic [15:0] count,
                              logic [31:0] len);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.address <= addr;
    in_ch.page_count <= count;
    in_ch.byte_length <= len;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_registers(logic [31:0] mem, logic [31:0] kend);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= CFG_MEMORY_BYTES;
    cfg_wdata <= mem;
    @(posedge clk);
    cfg_index <= CFG_KERNEL_END;
    cfg_wdata <= kend;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_request();
    int unsigned pick;
    logic [15:0] count;
    logic [31:0] addr;
    logic [31:0] len;
    bit wide;
    pick = $urandom_range(0, 99);
    wide = ($urandom_range(0, 15) == 0);
    addr = wide ? $urandom() : $urandom_range(0, 32'h003F_FFFF);
    len = wide ? $urandom() : $urandom_range(0, 32'h0002_0000);
    count = wide ? 16'($urandom()) : 16'($urandom_range(1, 64));
    if (pick < 5) begin
      send_request(ACT_INIT, $urandom(), 16'($urandom()), $urandom());
    end else if (pick < 50) begin
      if ($urandom_range(0, 49) != 0) count = 16'($urandom_range(0, 32));
      send_request(ACT_ALLOC, $urandom(), count, $urandom());
    end else if (pick < 80) begin
      send_request(ACT_FREE, addr, count, $urandom());
    end else begin
      send_request(ACT_RESERVE, addr, 16'($urandom()), len);
    end
  endtask

  initial begin
    logic [31:0] mem;
    logic [31:0] kend;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_MEMORY_BYTES;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_INIT;
    in_ch.address <= '0;
    in_ch.page_count <= '0;
    in_ch.byte_length <= '0;
    idle_on = 1'b1;
    rx_hold = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_registers(32'h0800_0000, 32'h0);
    send_request(ACT_ALLOC, 32'h0, 16'd3, 32'h0);
    send_request(ACT_INIT, 32'h0, 16'h0, 32'h0);
    send_request(ACT_ALLOC, 32'h0, 16'd0, 32'h0);
    send_request(ACT_ALLOC, 32'h0, 16'd1, 32'h0);
    send_request(ACT_ALLOC, 32'h0, 16'hFFFF, 32'h0);
    send_request(ACT_FREE, 32'h0, 16'd32768, 32'h0);
    send_request(ACT_ALLOC, 32'h0, 16'd32768, 32'h0);
    send_request(ACT_ALLOC, 32'h0, 16'd1, 32'h0);
    send_request(ACT_FREE, 32'h0, 16'hFFFF, 32'h0);
    send_request(ACT_ALLOC, 32'h0, 16'd1, 32'h0);
    send_request(ACT_RESERVE, 32'h0, 16'h0, 32'h0);
    send_request(ACT_RESERVE, 32'h0000_1000, 16'h0, 32'h1);
    send_request(ACT_RESERVE, 32'hFFFF_FFFF, 16'h0, 32'hFFFF_FFFF);
    send_request(ACT_RESERVE, 32'h07FF_F000, 16'h0, 32'h0001_0000);
    send_request(ACT_RESERVE, 32'h0001_2345, 16'h0, 32'h0000_5001);
    send_request(ACT_FREE, 32'hFFFF_FFFF, 16'd1, 32'h0);
    send_request(ACT_ALLOC, 32'hFFFF_FFFF, 16'd2, 32'hFFFF_FFFF);
    write_registers(32'h0, 32'h0);
    send_request(ACT_INIT, 32'h0, 16'h0, 32'h0);
    send_request(ACT_ALLOC, 32'h0, 16'd1, 32'h0);
    write_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_INIT, 32'h0, 16'h0, 32'h0);
    write_registers(32'hFFFF_FFFF, 32'h0030_0001);
    send_request(ACT_INIT, 32'h0, 16'h0, 32'h0);
    send_request(ACT_ALLOC, 32'h0, 16'd3, 32'h0);

    for (int phase = 0; phase < 9; phase++) begin
      case ($urandom_range(0, 3))
        0: mem = 32'hFFFF_FFFF;
        1: mem = $urandom();
        default: mem = $urandom_range(32'h0020_0000, 32'h0900_0000);
      endcase
      case ($urandom_range(0, 3))
        0: kend = 32'h0;
        1: kend = (phase == 4) ? $urandom() : $urandom_range(0, 32'h00FF_FFFF);
        default: kend = $urandom_range(0, 32'h0040_0000);
      endcase
      if (phase == 8) idle_on = 1'b0;
      write_registers(mem, kend);
      send_request(ACT_INIT, $urandom(), 16'($urandom()), $urandom());
      for (int n = 0; n < 62; n++) begin
        if (phase == 2 && n == 10) rx_hold = 1'b1;
        random_request();
      end
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("bitmap_page_run_allocator_core: match");
    else
      $display("bitmap_page_run_allocator_core: mismatch");
    $finish;
  end
endmodule
